/* rtl/rrfr_pkg.sv */
package rrfr_pkg;

  localparam int FrameDepth = 26;
  localparam int MaxPayload = 20;
  localparam int LenLimit   = (MaxPayload < FrameDepth - 6) ? MaxPayload : FrameDepth - 6;
  localparam int HeldW      = $clog2(FrameDepth + 1);
  localparam int IdxW       = $clog2(FrameDepth);
  localparam int LenW       = 5;
  localparam int CfgIdxW    = 3;

  localparam logic [15:0] ChConnect = 16'h0100;
  localparam logic [15:0] ChState   = 16'h0101;
  localparam logic [15:0] ChMotion  = 16'h0102;
  localparam logic [15:0] ChAnalog0 = 16'h0120;
  localparam logic [15:0] ChAnalog3 = 16'h0123;
  localparam logic [8:0]  SumMod    = 9'h0FF;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START     = 3'd0,
    CFG_READ      = 3'd1,
    CFG_WRITE     = 3'd2,
    CFG_WRITE_ACK = 3'd3,
    CFG_HIGHEST   = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_CONNECT   = 3'd0,
    KIND_STATE     = 3'd1,
    KIND_MOTION    = 3'd2,
    KIND_ANALOG    = 3'd3,
    KIND_WRITE     = 3'd4,
    KIND_WRITE_ACK = 3'd5
  } kind_e;

  typedef struct packed {
    logic append;
    logic drop;
    logic load_read;
    logic check_init;
    logic rot_step;
    logic load_write;
    logic clear;
  } rrfr_cmd_t;

  typedef struct packed {
    logic drop;
    logic wait_more;
    logic read_hit;
    logic write_hit;
    logic rot_last;
    logic sum_ok;
    logic emit_last;
    logic out_free;
  } rrfr_status_t;

endpackage

/* rtl/rrfr_datapath.sv */
module rrfr_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rrfr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [7:0]                     cfg_data_i,
  input  logic [7:0]                     rx_byte_i,
  input  rrfr_pkg::rrfr_cmd_t            cmd_i,
  output rrfr_pkg::rrfr_status_t         status_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [2:0]                     out_event_kind_o,
  output logic [15:0]                    out_channel_o,
  output logic [1:0]                     out_analog_pin_o,
  output logic [4:0]                     out_payload_length_o,
  output logic [7:0]                     out_payload_byte_o,
  output logic [4:0]                     out_byte_index_o,
  output logic                           out_last_o,
  output logic                           out_first_connect_o
);

  localparam int D = rrfr_pkg::FrameDepth;

  logic [7:0] start_q, read_q, write_q, write_ack_q, highest_q;
  logic [7:0] store_q [D];
  logic [7:0] rotated [D];
  logic [rrfr_pkg::HeldW-1:0] held_q;
  logic                       conn_q;
  logic [rrfr_pkg::IdxW-1:0]  rot_cnt_q;
  logic [7:0]                 sum_q;
  logic                       ok_q;
  logic [rrfr_pkg::LenW-1:0]  len_q, emit_idx_q;
  rrfr_pkg::kind_e            wkind_q;

  logic                       full;
  logic [rrfr_pkg::IdxW-1:0]  wr_idx;
  logic [15:0]                ch;
  logic [8:0]                 sum_add;
  logic [7:0]                 sum_d;
  logic [rrfr_pkg::HeldW-1:0] chk_pos;
  logic                       at_chk;
  logic                       is_connect, is_analog;
  rrfr_pkg::kind_e            rkind;

  for (genvar g = 0; g < D; g++) begin : g_rot
    assign rotated[g] = store_q[(g + 1) % D];
  end

  assign full   = (held_q >= rrfr_pkg::HeldW'(D));
  assign wr_idx = full ? rrfr_pkg::IdxW'(D - 1) : held_q[rrfr_pkg::IdxW-1:0];
  assign ch     = {store_q[2], store_q[3]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= 8'd0;
      read_q      <= 8'd0;
      write_q     <= 8'd1;
      write_ack_q <= 8'd2;
      highest_q   <= 8'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rrfr_pkg::CFG_START:     start_q     <= cfg_data_i;
        rrfr_pkg::CFG_READ:      read_q      <= cfg_data_i;
        rrfr_pkg::CFG_WRITE:     write_q     <= cfg_data_i;
        rrfr_pkg::CFG_WRITE_ACK: write_ack_q <= cfg_data_i;
        rrfr_pkg::CFG_HIGHEST:   highest_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Running checksum modulo 255; the partial sum stays below 255.
  assign sum_add = {1'b0, sum_q} + {1'b0, store_q[0]};
  assign sum_d   = (sum_add >= rrfr_pkg::SumMod) ? 8'(sum_add - rrfr_pkg::SumMod) : sum_add[7:0];
  assign chk_pos = rrfr_pkg::HeldW'(len_q) + rrfr_pkg::HeldW'(5);
  assign at_chk  = (rrfr_pkg::HeldW'(rot_cnt_q) == chk_pos);

  // Frame classification on the bytes at the head of the store.
  always_comb begin
    status_o.rot_last  = (rot_cnt_q == rrfr_pkg::IdxW'(D - 1));
    status_o.sum_ok    = ok_q;
    status_o.emit_last = (len_q == '0) || (emit_idx_q == len_q - rrfr_pkg::LenW'(1));
    status_o.out_free  = !out_valid_o || out_ready_i;
    status_o.drop      = 1'b0;
    status_o.wait_more = 1'b0;
    status_o.read_hit  = 1'b0;
    status_o.write_hit = 1'b0;
    if (held_q != '0 && store_q[0] != start_q) begin
      status_o.drop = 1'b1;
    end else if (held_q < rrfr_pkg::HeldW'(2)) begin
      status_o.wait_more = 1'b1;
    end else if (store_q[1] > highest_q) begin
      status_o.drop = 1'b1;
    end else if (held_q < rrfr_pkg::HeldW'(4)) begin
      status_o.wait_more = 1'b1;
    end else if (ch == rrfr_pkg::ChConnect) begin
      if (store_q[1] == read_q) begin
        status_o.read_hit = 1'b1;
      end else if (store_q[1] == write_q || store_q[1] == write_ack_q) begin
        if (held_q < rrfr_pkg::HeldW'(5)) begin
          status_o.wait_more = 1'b1;
        end else if (store_q[4] > 8'(rrfr_pkg::LenLimit)) begin
          status_o.drop = 1'b1;
        end else if (9'(held_q) < 9'(store_q[4]) + 9'd6) begin
          status_o.wait_more = 1'b1;
        end else begin
          status_o.write_hit = 1'b1;
        end
      end else begin
        status_o.drop = 1'b1;
      end
    end else if (store_q[1] == read_q && (ch == rrfr_pkg::ChState || ch == rrfr_pkg::ChMotion ||
             (ch >= rrfr_pkg::ChAnalog0 && ch <= rrfr_pkg::ChAnalog3))) begin
      status_o.read_hit = 1'b1;
    end else begin
      status_o.drop = 1'b1;
    end
  end

  assign is_connect = (ch == rrfr_pkg::ChConnect);
  assign is_analog  = (ch >= rrfr_pkg::ChAnalog0 && ch <= rrfr_pkg::ChAnalog3);

  always_comb begin
    if (is_connect) rkind = rrfr_pkg::KIND_CONNECT;
    else if (ch == rrfr_pkg::ChState) rkind = rrfr_pkg::KIND_STATE;
    else if (ch == rrfr_pkg::ChMotion) rkind = rrfr_pkg::KIND_MOTION;
    else rkind = rrfr_pkg::KIND_ANALOG;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < D; i++) begin
      if (cmd_i.append) begin
        if (full) begin
          store_q[i] <= (i == D - 1) ? rx_byte_i : rotated[i];
        end else if (rrfr_pkg::IdxW'(i) == wr_idx) begin
          store_q[i] <= rx_byte_i;
        end
      end else if (cmd_i.drop || cmd_i.rot_step || cmd_i.load_write) begin
        store_q[i] <= rotated[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      conn_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        held_q <= '0;
      end else if (cmd_i.append) begin
        held_q <= full ? held_q : held_q + rrfr_pkg::HeldW'(1);
      end else if (cmd_i.drop && held_q != '0) begin
        held_q <= held_q - rrfr_pkg::HeldW'(1);
      end
      if (cmd_i.load_read && is_connect) conn_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check_init) begin
      rot_cnt_q  <= '0;
      sum_q      <= 8'd0;
      ok_q       <= 1'b0;
      emit_idx_q <= '0;
      len_q      <= store_q[4][rrfr_pkg::LenW-1:0];
      wkind_q    <= (store_q[1] == write_ack_q) ? rrfr_pkg::KIND_WRITE_ACK
                                                : rrfr_pkg::KIND_WRITE;
    end else if (cmd_i.rot_step) begin
      rot_cnt_q <= rot_cnt_q + rrfr_pkg::IdxW'(1);
      if (rrfr_pkg::HeldW'(rot_cnt_q) < chk_pos) sum_q <= sum_d;
      if (at_chk) ok_q <= (sum_q == store_q[0]);
    end else if (cmd_i.load_write) begin
      emit_idx_q <= emit_idx_q + rrfr_pkg::LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load_read || cmd_i.load_write) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_read) begin
      out_event_kind_o     <= rkind;
      out_channel_o        <= ch;
      out_analog_pin_o     <= is_analog ? 2'(ch - rrfr_pkg::ChAnalog0) : 2'd0;
      out_payload_length_o <= '0;
      out_payload_byte_o   <= 8'd0;
      out_byte_index_o     <= '0;
      out_last_o           <= 1'b1;
      out_first_connect_o  <= is_connect && !conn_q;
    end else if (cmd_i.load_write) begin
      out_event_kind_o     <= wkind_q;
      out_channel_o        <= rrfr_pkg::ChConnect;
      out_analog_pin_o     <= 2'd0;
      out_payload_length_o <= len_q;
      out_payload_byte_o   <= (len_q == '0) ? 8'd0 : store_q[5];
      out_byte_index_o     <= emit_idx_q;
      out_last_o           <= status_o.emit_last;
      out_first_connect_o  <= 1'b0;
    end
  end

endmodule

/* rtl/rrfr_ctrl.sv */
module rrfr_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  rrfr_pkg::rrfr_status_t status_i,
  output rrfr_pkg::rrfr_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PARSE  = 5'b00010,
    ST_CHECK  = 5'b00100,
    ST_VERIFY = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.append = 1'b1;
          state_d      = ST_PARSE;
        end
      end
      ST_PARSE: begin
        priority if (status_i.drop) begin
          cmd_o.drop = 1'b1;
        end else if (status_i.wait_more) begin
          state_d = ST_IDLE;
        end else if (status_i.read_hit) begin
          // Hold the decision until the output register can take the item.
          if (status_i.out_free) begin
            cmd_o.load_read = 1'b1;
            cmd_o.clear     = 1'b1;
            state_d         = ST_IDLE;
          end
        end else if (status_i.write_hit) begin
          cmd_o.check_init = 1'b1;
          state_d          = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // A full rotation of the store brings it back to frame order.
        cmd_o.rot_step = 1'b1;
        if (status_i.rot_last) state_d = ST_VERIFY;
      end
      ST_VERIFY: begin
        if (status_i.sum_ok) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.drop = 1'b1;
          state_d    = ST_PARSE;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.load_write = 1'b1;
          if (status_i.emit_last) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

endmodule

/* rtl/resyncing_request_frame_receiver_top.sv */
// Request frame receiver for a serial byte stream.
// Input channel: one received byte per item on rx_byte_i (in_valid_i / in_ready_o).
// Output channel: one event item per result (out_valid_o / out_ready_i). A read
// request gives one item; a command write gives one item per payload byte, with
// out_last_o on the final one (an empty write gives a single item).
// Configuration: cfg_we_i writes cfg_data_i into the register cfg_index_i
// (start byte, read, write, write-with-ack and highest request codes).
// Bytes are taken one at a time: a new byte is accepted only when idle. A byte
// that completes nothing is parsed and the block returns to idle; bytes that
// cannot start a frame are dropped while resynchronizing. A write frame
// checksum check starts in the parse state, rotates the frame store once in
// the check state and decides in the verify state; a failed check then resumes
// parsing. Payload items are loaded in the emit state, each once the output
// register is free; a read result is loaded from the parse state likewise.
// When the receiver stalls, the output register holds its item; the next byte
// is still taken, and the block waits only when a new item is ready to load.
// Reset clears the held byte count, the connect flag and the registers to their
// default codes; the frame store itself needs no clearing.
module resyncing_request_frame_receiver_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rrfr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0]                   event_kind_o,
  output logic [15:0]                  channel_o,
  output logic [1:0]                   analog_pin_o,
  output logic [4:0]                   payload_length_o,
  output logic [7:0]                   payload_byte_o,
  output logic [4:0]                   byte_index_o,
  output logic                         last_o,
  output logic                         first_connect_o
);

  rrfr_pkg::rrfr_cmd_t    cmd;
  rrfr_pkg::rrfr_status_t status;

  rrfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rrfr_datapath u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .rx_byte_i            (rx_byte_i),
    .cmd_i                (cmd),
    .status_o             (status),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .out_event_kind_o     (event_kind_o),
    .out_channel_o        (channel_o),
    .out_analog_pin_o     (analog_pin_o),
    .out_payload_length_o (payload_length_o),
    .out_payload_byte_o   (payload_byte_o),
    .out_byte_index_o     (byte_index_o),
    .out_last_o           (last_o),
    .out_first_connect_o  (first_connect_o)
  );

endmodule

/* rtl/rrfr_checker.sv */
module rrfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  event_kind_o,
  input logic [4:0]  payload_length_o,
  input logic [4:0]  byte_index_o,
  input logic        last_o,
  input logic        first_connect_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output item withdrawn while stalled");

  // The block leaves its idle state only by taking a byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i))
    else $error("input ready dropped without an accepted item");

  // Read events are single items with no payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o != rrfr_pkg::KIND_WRITE &&
    event_kind_o != rrfr_pkg::KIND_WRITE_ACK |-> last_o && payload_length_o == 5'd0)
    else $error("read event with payload");

  // A first-connect flag only rides on a connect read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && first_connect_o |-> event_kind_o == rrfr_pkg::KIND_CONNECT)
    else $error("first connect on a non-connect event");

  // Payload positions stay within the payload length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && payload_length_o != 5'd0 |-> byte_index_o < payload_length_o)
    else $error("payload index out of range");

endmodule

bind resyncing_request_frame_receiver_top rrfr_checker u_rrfr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .event_kind_o     (event_kind_o),
  .payload_length_o (payload_length_o),
  .byte_index_o     (byte_index_o),
  .last_o           (last_o),
  .first_connect_o  (first_connect_o)
);
